// File: design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define PCDS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define PCDS_NEVER(lbl, clk, rst, cond, msg) \
   `PCDS_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// File: design/pcds_pkg.sv
// ---------------------------------------------------------------------------
// pcds_pkg
// Shared constants and codes of the point cloud depth splat block.
// ---------------------------------------------------------------------------
package pcds_pkg;

   localparam int DEF_MAX_WIDTH  = 512;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int CFG_W       = 20;
   localparam int CSR_IDX_W   = 3;
   localparam int DEPTH_W     = 15;
   localparam int COUNT_W     = 4;
   localparam int CELL_IDX_W  = 17;
   localparam int MWIDTH_W    = 10;
   localparam int MHEIGHT_W   = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT   = 3'd5;

   localparam logic [CFG_W-1:0]     RST_FOCAL_X  = 20'd65536;
   localparam logic [CFG_W-1:0]     RST_FOCAL_Y  = 20'd65536;
   localparam logic [CFG_W-1:0]     RST_CENTER_X = 20'd40960;
   localparam logic [CFG_W-1:0]     RST_CENTER_Y = 20'd23040;
   localparam logic [MWIDTH_W-1:0]  RST_WIDTH    = 10'd320;
   localparam logic [MHEIGHT_W-1:0] RST_HEIGHT   = 9'd180;

   localparam logic [1:0] OP_CLEAR   = 2'd0;
   localparam logic [1:0] OP_PROJECT = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;
   localparam logic [1:0] OP_NOP     = 2'd3;

   // shared multiplier steps
   localparam logic [2:0] MS_XF  = 3'd0;
   localparam logic [2:0] MS_CXZ = 3'd1;
   localparam logic [2:0] MS_YF  = 3'd2;
   localparam logic [2:0] MS_CYZ = 3'd3;
   localparam logic [2:0] MS_ZK  = 3'd4;
   localparam logic [2:0] MS_VW  = 3'd5;
   localparam logic [2:0] MS_WH  = 3'd6;

   localparam logic signed [20:0] MM_PER_M  = 21'sd1000;
   localparam logic [DEPTH_W-1:0] DEPTH_SAT = 15'd32767;

   // division operands: 2|n| + d over 2d, with headroom
   localparam int DIV_W = 56;

endpackage

// File: design/pcds_store.sv
// ---------------------------------------------------------------------------
// pcds_store
// Depth map memory: one write port, one registered read port.
// ---------------------------------------------------------------------------
module pcds_store import pcds_pkg::*; #(
   parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_HEIGHT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [DEPTH_W-1:0] rd_data,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [DEPTH_W-1:0] wr_data
);

   logic [DEPTH_W-1:0] store_ff [DEPTH];
   logic [DEPTH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/pcds_div.sv
// ---------------------------------------------------------------------------
// pcds_div
// Restoring divider, one quotient bit per cycle, with overflow flag.
// ---------------------------------------------------------------------------
module pcds_div import pcds_pkg::*; #(
   parameter int QB = 10
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] num,
   input  logic [DIV_W-1:0] den,
   output logic             done,
   output logic [QB-1:0]    quot,
   output logic             ovf
);

   localparam int CNT_W = $clog2(QB + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dsh_ff, dsh_in;
   logic [QB-1:0]    q_ff, q_in;
   logic             ovf_ff, ovf_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic             ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      q_in    = q_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num;
         dsh_in = den << (QB - 1);
         ovf_in = num >= (den << QB);
         q_in   = '0;
         cnt_in = CNT_W'(QB - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? rem_ff - dsh_ff : rem_ff;
         q_in   = {q_ff[QB-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      ovf_ff <= ovf_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign ovf  = ovf_ff;

endmodule

// File: design/point_cloud_depth_splat.sv
// ---------------------------------------------------------------------------
// point_cloud_depth_splat
// Projects 3D points through a pinhole camera into a sparse depth map.
// ---------------------------------------------------------------------------
// One command at a time; busy is high while it runs and every command gives
// exactly one rsp_valid beat, in the first cycle with busy low, which the
// receiver cannot stall. A clear writes one cell a cycle through the single
// write port, then moves to S_DONE; the same sweep runs after reset with busy
// high and no response. A read steps through S_RD, S_RDW, S_RDD and S_DONE; a
// no-op or a point with z not positive goes straight to S_DONE. A projection
// runs seven products through one shared 33x21 multiplier, two quotients of
// QB = clog2(max(MAX_WIDTH,MAX_HEIGHT))+1 bits through one restoring divider,
// and then visits each of the nine box cells through S_BOXA, S_BOXR and, for
// a cell on the map, S_BOXW on the map port; a point that falls off the map
// is dropped after the second quotient. Config writes are always ready.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module point_cloud_depth_splat import pcds_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [1:0]               req_opcode,
   input  logic signed [31:0]       req_x_pos,
   input  logic signed [31:0]       req_y_pos,
   input  logic signed [31:0]       req_z_pos,
   input  logic [CELL_IDX_W-1:0]    req_cell_index,
   output logic                     rsp_valid,
   output logic [DEPTH_W-1:0]       rsp_depth_mm,
   output logic [COUNT_W-1:0]       rsp_cells_written,
   output logic                     rsp_point_dropped,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CFG_W-1:0]         csr_wdata
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = AW + 2;
   localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int QB    = $clog2(MAXD) + 1;
   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int EWW   = (CW > MWIDTH_W) ? CW : MWIDTH_W;
   localparam int EHW   = (HW > MHEIGHT_W) ? HW : MHEIGHT_W;
   localparam int EXW   = ((AW > CELL_IDX_W) ? AW : CELL_IDX_W) + 1;
   localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
   localparam logic [EXW-1:0] CELLS_X   = EXW'(CELLS);

   typedef enum logic [11:0] {
      S_IDLE = 12'b0000_0000_0001,
      S_CLR  = 12'b0000_0000_0010,
      S_RD   = 12'b0000_0000_0100,
      S_RDW  = 12'b0000_0000_1000,
      S_MUL  = 12'b0000_0001_0000,
      S_DIVU = 12'b0000_0010_0000,
      S_DIVV = 12'b0000_0100_0000,
      S_BOXA = 12'b0000_1000_0000,
      S_BOXR = 12'b0001_0000_0000,
      S_BOXW = 12'b0010_0000_0000,
      S_DONE = 12'b0100_0000_0000,
      S_RDD  = 12'b1000_0000_0000
   } state_type;

   // config
   logic [CFG_W-1:0]     fx_ff, fy_ff, cx_ff, cy_ff;
   logic [MWIDTH_W-1:0]  mw_ff;
   logic [MHEIGHT_W-1:0] mh_ff;
   logic [CW-1:0]        w_eff;
   logic [HW-1:0]        h_eff;

   // control
   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 clr_cmd_ff, clr_cmd_in;
   logic [2:0]           mstep_ff, mstep_in;
   logic [2:0]           pstep_ff;
   logic                 pval_ff;
   logic [1:0]           row_ff, row_in, col_ff, col_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload
   logic signed [31:0]   x_ff, y_ff, z_ff;
   logic [AW-1:0]        cidx_ff;
   logic                 cin_ff;
   logic signed [53:0]   prod_ff;
   logic signed [53:0]   nx_ff, nx_in, ny_ff, ny_in;
   logic [DEPTH_W-1:0]   dep_ff, dep_in;
   logic [QB-1:0]        uq_ff, uq_in, vq_ff, vq_in;
   logic                 uoff_ff, uoff_in;
   logic signed [IW-1:0] base_ff, base_in, total_ff, total_in;
   logic signed [IW-1:0] rbase_ff, rbase_in, idx_ff, idx_in;
   logic [DEPTH_W-1:0]   odep_ff, odep_in;
   logic [COUNT_W-1:0]   ocnt_ff, ocnt_in;
   logic                 odrop_ff, odrop_in;

   // shared multiplier
   logic signed [32:0]   mul_a;
   logic signed [20:0]   mul_b;

   // divider
   logic                 div_start, div_done, div_ovf;
   logic [DIV_W-1:0]     div_num, div_den, num_u, num_v;
   logic [QB-1:0]        div_q;
   logic [53:0]          absx, absy;
   logic                 q_off_u, q_off_v;

   // store
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr, wr_addr;
   logic [DEPTH_W-1:0]   rd_data, wr_data;
   logic [41:0]          dround;
   logic                 idx_ok, accept;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // ---- config registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= RST_FOCAL_X;
         fy_ff <= RST_FOCAL_Y;
         cx_ff <= RST_CENTER_X;
         cy_ff <= RST_CENTER_Y;
         mw_ff <= RST_WIDTH;
         mh_ff <= RST_HEIGHT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL_X:  fx_ff <= csr_wdata;
            CSR_FOCAL_Y:  fy_ff <= csr_wdata;
            CSR_CENTER_X: cx_ff <= csr_wdata;
            CSR_CENTER_Y: cy_ff <= csr_wdata;
            CSR_WIDTH:    mw_ff <= csr_wdata[MWIDTH_W-1:0];
            CSR_HEIGHT:   mh_ff <= csr_wdata[MHEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign w_eff = (EWW'(mw_ff) < EWW'(MAX_WIDTH)) ? CW'(mw_ff) : CW'(MAX_WIDTH);
   assign h_eff = (EHW'(mh_ff) < EHW'(MAX_HEIGHT)) ? HW'(mh_ff) : HW'(MAX_HEIGHT);

   // ---- shared multiplier ----
   always_comb begin
      unique case (mstep_ff)
         MS_XF:   begin mul_a = 33'(x_ff);   mul_b = $signed({1'b0, fx_ff}); end
         MS_CXZ:  begin mul_a = 33'(z_ff);   mul_b = $signed({1'b0, cx_ff}); end
         MS_YF:   begin mul_a = 33'(y_ff);   mul_b = $signed({1'b0, fy_ff}); end
         MS_CYZ:  begin mul_a = 33'(z_ff);   mul_b = $signed({1'b0, cy_ff}); end
         MS_ZK:   begin mul_a = 33'(z_ff);   mul_b = MM_PER_M; end
         MS_VW:   begin
            mul_a = $signed({{(33-QB){1'b0}}, vq_ff});
            mul_b = $signed({{(21-CW){1'b0}}, w_eff});
         end
         MS_WH:   begin
            mul_a = $signed({{(33-HW){1'b0}}, h_eff});
            mul_b = $signed({{(21-CW){1'b0}}, w_eff});
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff  <= mul_a * mul_b;
      pstep_ff <= mstep_ff;
      if (reset) begin
         pval_ff <= 1'b0;
      end else begin
         pval_ff <= (state_ff == S_MUL);
      end
   end

   assign dround = prod_ff[41:0] + 42'd32768;

   // ---- divider operands: (2|n| + 256z) / (512z) ----
   assign absx    = nx_ff[53] ? 54'(-nx_ff) : 54'(nx_ff);
   assign absy    = ny_ff[53] ? 54'(-ny_ff) : 54'(ny_ff);
   assign num_u   = {1'b0, absx, 1'b0} + {16'b0, z_ff, 8'b0};
   assign num_v   = {1'b0, absy, 1'b0} + {16'b0, z_ff, 8'b0};
   assign div_den = {15'b0, z_ff, 9'b0};
   assign div_num = (state_ff == S_MUL) ? num_u : num_v;
   assign div_start = ((state_ff == S_MUL) && pval_ff && (pstep_ff == MS_ZK)) ||
                      ((state_ff == S_DIVU) && div_done);
   assign q_off_u = div_ovf || (nx_ff[53] && (div_q != '0)) || (div_q >= QB'(w_eff));
   assign q_off_v = div_ovf || (ny_ff[53] && (div_q != '0)) || (div_q >= QB'(h_eff));

   pcds_div #(.QB(QB)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q),
      .ovf   (div_ovf)
   );

   assign idx_ok = !idx_ff[IW-1] && (idx_ff < total_ff);

   // ---- sequencer ----
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_cmd_in   = clr_cmd_ff;
      mstep_in     = mstep_ff + 1'b1;
      row_in       = row_ff;
      col_in       = col_ff;
      rsp_valid_in = 1'b0;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      dep_in       = dep_ff;
      uq_in        = uq_ff;
      vq_in        = vq_ff;
      uoff_in      = uoff_ff;
      base_in      = base_ff;
      total_in     = total_ff;
      rbase_in     = rbase_ff;
      idx_in       = idx_ff;
      odep_in      = odep_ff;
      ocnt_in      = ocnt_ff;
      odrop_in     = odrop_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = dep_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               odep_in  = '0;
               ocnt_in  = '0;
               odrop_in = 1'b0;
               unique case (req_opcode)
                  OP_CLEAR: begin
                     state_in   = S_CLR;
                     clr_in     = '0;
                     clr_cmd_in = 1'b1;
                  end
                  OP_PROJECT: begin
                     if (req_z_pos[31] || (req_z_pos == '0)) begin
                        odrop_in = 1'b1;
                        state_in = S_DONE;
                     end else begin
                        mstep_in = MS_XF;
                        state_in = S_MUL;
                     end
                  end
                  OP_READ: state_in = S_RD;
                  OP_NOP:  state_in = S_DONE;
               endcase
            end
         end
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_CELL) begin
               state_in = clr_cmd_ff ? S_DONE : S_IDLE;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = cidx_ff;
            state_in = S_RDW;
         end
         S_RDW: begin
            state_in = S_RDD;
         end
         S_RDD: begin
            odep_in  = cin_ff ? rd_data : '0;
            state_in = S_DONE;
         end
         S_MUL: begin
            if (pval_ff) begin
               unique case (pstep_ff)
                  MS_XF:  nx_in = prod_ff;
                  MS_CXZ: nx_in = nx_ff + prod_ff;
                  MS_YF:  ny_in = prod_ff;
                  MS_CYZ: ny_in = ny_ff + prod_ff;
                  MS_ZK: begin
                     dep_in   = (dround[41:31] != '0) ? DEPTH_SAT : dround[30:16];
                     state_in = S_DIVU;
                  end
                  MS_VW:  base_in = prod_ff[IW-1:0] + $signed({{(IW-QB){1'b0}}, uq_ff});
                  MS_WH: begin
                     total_in = prod_ff[IW-1:0];
                     rbase_in = base_ff - $signed({{(IW-CW){1'b0}}, w_eff});
                     row_in   = '0;
                     col_in   = '0;
                     state_in = S_BOXA;
                  end
                  default: ;
               endcase
            end
         end
         S_DIVU: begin
            if (div_done) begin
               uq_in    = nx_ff[53] ? '0 : div_q;
               uoff_in  = q_off_u;
               state_in = S_DIVV;
            end
         end
         S_DIVV: begin
            if (div_done) begin
               vq_in = ny_ff[53] ? '0 : div_q;
               if (uoff_ff || q_off_v) begin
                  odrop_in = 1'b1;
                  state_in = S_DONE;
               end else begin
                  mstep_in = MS_VW;
                  state_in = S_MUL;
               end
            end
         end
         S_BOXA: begin
            idx_in   = rbase_ff + $signed({{(IW-2){1'b0}}, col_ff}) - IW'(1);
            state_in = S_BOXR;
         end
         S_BOXR, S_BOXW: begin
            if ((state_ff == S_BOXR) && idx_ok) begin
               rd_en    = 1'b1;
               state_in = S_BOXW;
            end else begin
               if ((state_ff == S_BOXW) && (rd_data == '0)) begin
                  wr_en = 1'b1;
                  if (dep_ff != '0) begin
                     ocnt_in = ocnt_ff + 1'b1;
                  end
               end
               state_in = S_BOXA;
               col_in   = col_ff + 1'b1;
               if (col_ff == 2'd2) begin
                  col_in   = '0;
                  row_in   = row_ff + 1'b1;
                  rbase_in = rbase_ff + $signed({{(IW-CW){1'b0}}, w_eff});
                  if (row_ff == 2'd2) begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         clr_cmd_ff   <= 1'b0;
         mstep_ff     <= MS_XF;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_cmd_ff   <= clr_cmd_in;
         mstep_ff     <= mstep_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff    <= req_x_pos;
         y_ff    <= req_y_pos;
         z_ff    <= req_z_pos;
         cidx_ff <= EXW'(req_cell_index) < CELLS_X ? AW'(req_cell_index) : '0;
         cin_ff  <= EXW'(req_cell_index) < CELLS_X;
      end
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      dep_ff   <= dep_in;
      uq_ff    <= uq_in;
      vq_ff    <= vq_in;
      uoff_ff  <= uoff_in;
      base_ff  <= base_in;
      total_ff <= total_in;
      rbase_ff <= rbase_in;
      idx_ff   <= idx_in;
      odep_ff  <= odep_in;
      ocnt_ff  <= ocnt_in;
      odrop_ff <= odrop_in;
   end

   pcds_store #(.DEPTH(CELLS), .AW(AW)) u_store (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_depth_mm      = odep_ff;
   assign rsp_cells_written = ocnt_ff;
   assign rsp_point_dropped = odrop_ff;

   `PCDS_ASSERT(a_one_beat, clock, reset, rsp_valid |=> !rsp_valid, "back-to-back beats")
   `PCDS_ASSERT(a_cnt_max, clock, reset, rsp_valid |-> (rsp_cells_written <= 4'd9), "count > 9")
   `PCDS_ASSERT(a_drop_nowr, clock, reset, (rsp_valid && rsp_point_dropped) |-> (rsp_cells_written == '0), "dropped point wrote cells")
   `PCDS_NEVER(a_wr_state, clock, reset, wr_en && (state_ff != S_CLR) && (state_ff != S_BOXW), "stray map write")

endmodule

// File: tb/point_cloud_depth_splat_tb.sv
// ---------------------------------------------------------------------------
// point_cloud_depth_splat_tb
// Self-checking regression of the depth splat block: directed and random
// commands over several camera and map settings, checked beat by beat
// against an internal model of the projection and the depth map.
// ---------------------------------------------------------------------------
module point_cloud_depth_splat_tb import pcds_pkg::*; ();

   localparam int     STORE_CELLS = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
   localparam longint CYCLE_LIMIT = 4_000_000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = CSR_HEIGHT + 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = CSR_HEIGHT + 3'd2;

   typedef struct {
      logic [DEPTH_W-1:0] depth_mm;
      logic [COUNT_W-1:0] cells_written;
      logic               point_dropped;
   } splat_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [1:0]            req_opcode = OP_NOP;
   logic signed [31:0]    req_x_pos = '0;
   logic signed [31:0]    req_y_pos = '0;
   logic signed [31:0]    req_z_pos = '0;
   logic [CELL_IDX_W-1:0] req_cell_index = '0;
   logic                  rsp_valid;
   logic [DEPTH_W-1:0]    rsp_depth_mm;
   logic [COUNT_W-1:0]    rsp_cells_written;
   logic                  rsp_point_dropped;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]      csr_wdata = '0;

   // model state
   logic [DEPTH_W-1:0]    shadow_map [STORE_CELLS];
   logic [CFG_W-1:0]      cam_fx, cam_fy, cam_cx, cam_cy;
   logic [MWIDTH_W-1:0]   cols_reg;
   logic [MHEIGHT_W-1:0]  rows_reg;

   splat_rsp_type         pending[$];
   int                    mismatches = 0;
   longint                cycles = 0;
   bit                    no_gaps = 1'b0;
   int                    last_cell = 0;

   point_cloud_depth_splat uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("point_cloud_depth_splat regression: fail");
         $finish;
      end
   end

   function automatic int cols_used();
      return (cols_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cols_reg);
   endfunction

   function automatic int rows_used();
      return (rows_reg > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(rows_reg);
   endfunction

   function automatic longint nearest_div(longint n, longint d);
      if (n >= 0) return (2 * n + d) / (2 * d);
      return -((2 * (-n) + d) / (2 * d));
   endfunction

   // applies one command to the model map, returns the expected beat
   function automatic splat_rsp_type splat_apply(logic [1:0] op, logic signed [31:0] x,
                                                 logic signed [31:0] y, logic signed [31:0] z,
                                                 logic [CELL_IDX_W-1:0] idx);
      splat_rsp_type r;
      longint xs, ys, zs, w, h, u, v, d, lin_idx;
      r = '{default: '0};
      xs = x;
      ys = y;
      zs = z;
      case (op)
         OP_CLEAR: begin
            foreach (shadow_map[i]) shadow_map[i] = '0;
         end
         OP_READ: begin
            if (idx < STORE_CELLS) r.depth_mm = shadow_map[idx];
         end
         OP_PROJECT: begin
            if (zs <= 0) begin
               r.point_dropped = 1'b1;
            end else begin
               w = cols_used();
               h = rows_used();
               u = nearest_div(xs * longint'(cam_fx) + longint'(cam_cx) * zs, zs * 256);
               v = nearest_div(ys * longint'(cam_fy) + longint'(cam_cy) * zs, zs * 256);
               d = (zs * 1000 + 32768) >>> 16;
               if (d > DEPTH_SAT) d = DEPTH_SAT;
               if (u < 0 || u >= w || v < 0 || v >= h) begin
                  r.point_dropped = 1'b1;
               end else begin
                  for (int a = -1; a <= 1; a++) begin
                     for (int b = -1; b <= 1; b++) begin
                        lin_idx = (v + a) * w + u + b;
                        if (lin_idx >= 0 && lin_idx < w * h && shadow_map[lin_idx] == 0) begin
                           shadow_map[lin_idx] = d[DEPTH_W-1:0];
                           if (d != 0) r.cells_written++;
                        end
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      splat_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: depth %0d cells %0d dropped %0d",
                        rsp_depth_mm, rsp_cells_written, rsp_point_dropped);
         end else begin
            want = pending.pop_front();
            if (want.depth_mm !== rsp_depth_mm || want.cells_written !== rsp_cells_written
                || want.point_dropped !== rsp_point_dropped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected depth %0d cells %0d dropped %0d, got %0d %0d %0d",
                           want.depth_mm, want.cells_written, want.point_dropped,
                           rsp_depth_mm, rsp_cells_written, rsp_point_dropped);
            end
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_cmd(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z, logic [CELL_IDX_W-1:0] idx);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode = op;
      req_x_pos = x;
      req_y_pos = y;
      req_z_pos = z;
      req_cell_index = idx;
      start = 1'b1;
      while (busy) @(negedge clock);
      @(posedge clock);
      pending.push_back(splat_apply(op, x, y, z, idx));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start = 1'b0;
      while (pending.size() != 0 || busy) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      wait_idle();
      while (!csr_ready) @(negedge clock);
      csr_index = idx;
      csr_wdata = data;
      csr_valid = 1'b1;
      @(posedge clock);
      case (idx)
         CSR_FOCAL_X:  cam_fx = data;
         CSR_FOCAL_Y:  cam_fy = data;
         CSR_CENTER_X: cam_cx = data;
         CSR_CENTER_Y: cam_cy = data;
         CSR_WIDTH:    cols_reg = data[MWIDTH_W-1:0];
         CSR_HEIGHT:   rows_reg = data[MHEIGHT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // aims a point at a chosen pixel under the current camera
   task automatic send_aimed();
      longint zz, xx, yy, u, v;
      int w, h;
      w = cols_used();
      h = rows_used();
      case ($urandom_range(0, 9))
         0: zz = $urandom_range(1, 64);
         1: zz = $urandom_range(1, 32'h7fffffff);
         default: zz = $urandom_range(6554, 20 * 65536);
      endcase
      u = (w == 0) ? 0 : ($urandom_range(0, 4) == 0 ? (($urandom_range(0, 1)) ? w - 1 : 0)
                                                    : $urandom_range(0, w - 1));
      v = (h == 0) ? 0 : ($urandom_range(0, 4) == 0 ? (($urandom_range(0, 1)) ? h - 1 : 0)
                                                    : $urandom_range(0, h - 1));
      xx = (cam_fx == 0) ? longint'($signed($urandom()))
                         : zz * (u * 256 - longint'(cam_cx)) / longint'(cam_fx);
      yy = (cam_fy == 0) ? longint'($signed($urandom()))
                         : zz * (v * 256 - longint'(cam_cy)) / longint'(cam_fy);
      if ($urandom_range(0, 3) == 0) begin
         xx += longint'($urandom_range(0, 64)) - 32;
         yy += longint'($urandom_range(0, 64)) - 32;
      end
      last_cell = int'(v * w + u);
      send_cmd(OP_PROJECT, clamp32(xx), clamp32(yy), clamp32(zz), '0);
   endtask

   task automatic run_mix(int n);
      int r;
      for (int k = 0; k < n; k++) begin
         if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         if (r < 62) send_aimed();
         else if (r < 80)
            send_cmd(OP_READ, $urandom(), $urandom(), $urandom(),
                     CELL_IDX_W'(last_cell + $urandom_range(0, 1200) - 600));
         else if (r < 86)
            send_cmd(OP_READ, $urandom(), $urandom(), $urandom(), CELL_IDX_W'($urandom()));
         else if (r < 95)
            send_cmd(OP_PROJECT, $urandom(), $urandom(), $urandom(), CELL_IDX_W'($urandom()));
         else
            send_cmd(OP_NOP, $urandom(), $urandom(), $urandom(), CELL_IDX_W'($urandom()));
      end
      no_gaps = 1'b0;
   endtask

   task automatic test_directed();
      send_cmd(OP_READ, '0, '0, '0, '0);
      send_cmd(OP_NOP, '1, '1, '1, '1);
      send_cmd(OP_PROJECT, 0, 0, 1, '0);
      send_cmd(OP_READ, '0, '0, '0, CELL_IDX_W'(90 * 320 + 160));
      send_cmd(OP_PROJECT, 0, 0, 65536, '0);
      send_cmd(OP_PROJECT, 0, 0, 65536, '0);
      send_cmd(OP_READ, '0, '0, '0, CELL_IDX_W'(91 * 320 + 161));
      send_cmd(OP_PROJECT, 0, 0, 0, '0);
      send_cmd(OP_PROJECT, 0, 0, 32'sh80000000, '0);
      send_cmd(OP_PROJECT, 0, 256, 32'sh7fffffff, '0);
      send_cmd(OP_PROJECT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, '0);
      send_cmd(OP_PROJECT, -40960, -23040, 65536, '0);
      send_cmd(OP_PROJECT, 40704, 22784, 65536, '0);
      send_cmd(OP_PROJECT, 40704, -10240, 65536, '0);
      send_cmd(OP_PROJECT, 32'sh80000000, 0, 65536, '0);
      send_cmd(OP_PROJECT, 32'sh7fffffff, 0, 65536, '0);
      send_cmd(OP_READ, '0, '0, '0, CELL_IDX_W'(51 * 320));
      send_cmd(OP_READ, '0, '0, '0, CELL_IDX_W'(179 * 320 + 319));
      send_cmd(OP_READ, '0, '0, '0, '1);
      send_cmd(OP_CLEAR, '0, '0, '0, '0);
      send_cmd(OP_READ, '0, '0, '0, CELL_IDX_W'(90 * 320 + 160));
   endtask

   task automatic test_clamped_size();
      write_csr(CSR_WIDTH, 20'd1023);
      write_csr(CSR_HEIGHT, 20'd511);
      write_csr(CSR_CENTER_X, 20'd65536);
      write_csr(CSR_CENTER_Y, 20'd32768);
      run_mix(200);
   endtask

   task automatic test_tiny_map();
      write_csr(CSR_WIDTH, 20'd1);
      write_csr(CSR_HEIGHT, 20'd1);
      write_csr(CSR_CENTER_X, 20'd0);
      write_csr(CSR_CENTER_Y, 20'd0);
      send_cmd(OP_CLEAR, '0, '0, '0, '0);
      run_mix(60);
      write_csr(CSR_WIDTH, 20'd3);
      write_csr(CSR_HEIGHT, 20'd2);
      run_mix(60);
   endtask

   task automatic test_zero_size();
      write_csr(CSR_WIDTH, 20'd0);
      run_mix(20);
      write_csr(CSR_WIDTH, 20'd5);
      write_csr(CSR_HEIGHT, 20'd0);
      run_mix(20);
   endtask

   task automatic test_camera_extremes();
      write_csr(CSR_WIDTH, 20'd512);
      write_csr(CSR_HEIGHT, 20'd256);
      write_csr(CSR_FOCAL_X, 20'd0);
      write_csr(CSR_FOCAL_Y, 20'd0);
      run_mix(60);
      write_csr(CSR_FOCAL_X, 20'hFFFFF);
      write_csr(CSR_FOCAL_Y, 20'hFFFFF);
      write_csr(CSR_CENTER_X, 20'hFFFFF);
      write_csr(CSR_CENTER_Y, 20'hFFFFF);
      run_mix(60);
   endtask

   task automatic test_spare_index();
      write_csr(CSR_SPARE_LO, 20'hFFFFF);
      write_csr(CSR_SPARE_HI, 20'h00001);
      run_mix(20);
   endtask

   task automatic test_random_cameras();
      int w, h;
      for (int p = 0; p < 6; p++) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 600) : $urandom_range(1, 40);
         h = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 300) : $urandom_range(1, 40);
         write_csr(CSR_WIDTH, CFG_W'(w));
         write_csr(CSR_HEIGHT, CFG_W'(h));
         write_csr(CSR_FOCAL_X, CFG_W'($urandom_range(8192, 400000)));
         write_csr(CSR_FOCAL_Y, CFG_W'($urandom_range(8192, 400000)));
         write_csr(CSR_CENTER_X, CFG_W'(w * 128 + $urandom_range(0, 2000)));
         write_csr(CSR_CENTER_Y, CFG_W'(h * 128 + $urandom_range(0, 2000)));
         if (p == 2 || p == 4) send_cmd(OP_CLEAR, '0, '0, '0, '0);
         run_mix(210);
      end
   endtask

   initial begin
      cam_fx = RST_FOCAL_X;
      cam_fy = RST_FOCAL_Y;
      cam_cx = RST_CENTER_X;
      cam_cy = RST_CENTER_Y;
      cols_reg = RST_WIDTH;
      rows_reg = RST_HEIGHT;
      foreach (shadow_map[i]) shadow_map[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_clamped_size();
      test_tiny_map();
      test_zero_size();
      test_camera_extremes();
      test_spare_index();
      test_random_cameras();
      wait_idle();
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("point_cloud_depth_splat regression: pass");
      end else begin
         $display("point_cloud_depth_splat regression: fail");
      end
      $finish;
   end

endmodule
